FILE: sv/adpc_pkg.sv
`default_nettype none
// ============================================================================
// adpc_pkg
// Types and constants shared by the deadband position control block.
// ============================================================================
package adpc_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TARGET_W   = 10;
    localparam int MODE_W     = 2;
    localparam int POS_W      = 10;
    localparam int TOL_W      = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    // Sign-extended compare width: holds target +/- tolerance without wrap
    localparam int CMP_W      = 12;

    // Scaling: position = floor(x * SCALE_SPAN / SAMPLE_MAX) + POS_MIN
    localparam int SAMPLE_MAX = 1023;
    localparam int SCALE_SPAN = 510;
    localparam int POS_MIN    = 10;
    localparam int PROD_W     = 19;

    localparam logic [MODE_W-1:0] MODE_WINDOW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AT_LEAST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AT_MOST  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 1'd1;

    typedef enum logic [1:0] {
        DIR_OFF = 2'd0,
        DIR_POS = 2'd1,
        DIR_NEG = 2'd2
    } dir_t;

    typedef struct packed {
        dir_t dir;
        logic drive_positive;
        logic drive_negative;
    } drive_t;

endpackage
`default_nettype wire

FILE: sv/adpc_if.sv
`default_nettype none
// ============================================================================
// adpc_in_if / adpc_out_if
// Valid/ready channels carrying feedback items in and control results out.
// ============================================================================
interface adpc_in_if;
    logic                           valid;
    logic                           ready;
    logic [adpc_pkg::SAMPLE_W-1:0]  adc_sample;
    logic [adpc_pkg::TARGET_W-1:0]  target_position;
    logic [adpc_pkg::MODE_W-1:0]    mode;

    modport source (output valid, output adc_sample, output target_position,
                    output mode, input ready);
    modport sink   (input valid, input adc_sample, input target_position,
                    input mode, output ready);
endinterface

interface adpc_out_if;
    logic                         valid;
    logic                         ready;
    logic [adpc_pkg::POS_W-1:0]   position;
    logic                         drive_positive;
    logic                         drive_negative;
    logic                         running;
    logic                         direction_changed;

    modport source (output valid, output position, output drive_positive,
                    output drive_negative, output running,
                    output direction_changed, input ready);
    modport sink   (input valid, input position, input drive_positive,
                    input drive_negative, input running,
                    input direction_changed, output ready);
endinterface
`default_nettype wire

FILE: sv/actuator_deadband_position_control.sv
`default_nettype none
// ============================================================================
// actuator_deadband_position_control
// Bang-bang actuator position control with a deadband around the target.
// ============================================================================
//
//  Channel   Dir  Handshake      Payload
//  --------  ---  -------------  -------------------------------------------
//  in_ch     in   valid/ready    adc_sample, target_position, mode
//  out_ch    out  valid/ready    position, drive_positive, drive_negative,
//                                running, direction_changed
//  cfg       in   cfg_write_en   cfg_index, cfg_data (tolerance, invert)
//
//  A transaction passes through one input register, then scaling and compare
//  logic into the result register. One transaction per cycle is sustained
//  while out_ch does not stall. Reset clears the valid flags, the configuration
//  and the last direction (off). A stall on out_ch holds the result register
//  and backs up into the input register; in_ch stays ready while either stage
//  has room.
//
module actuator_deadband_position_control (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    adpc_in_if.sink                               in_ch,
    adpc_out_if.source                            out_ch,
    input  wire logic                             cfg_write_en,
    input  wire logic [adpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [adpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import adpc_pkg::*;

    // Configuration
    logic [TOL_W-1:0]    tolerance_reg;
    logic                invert_reg;

    // Input stage
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [MODE_W-1:0]   mode_reg;

    // Result stage
    logic                out_valid_reg;
    logic [POS_W-1:0]    position_reg;
    logic                drive_pos_reg;
    logic                drive_neg_reg;
    logic                running_reg;
    logic                changed_reg;

    dir_t                last_dir_reg;
    dir_t                last_dir_next;

    logic                out_advance;
    logic                in_advance;
    logic                in_take;
    logic [POS_W-1:0]    position;
    drive_t              drive;

    // Move the input stage forward whenever the result register is free
    assign out_advance = ~out_valid_reg | out_ch.ready;
    assign in_advance  = in_valid_reg & out_advance;
    assign in_ch.ready = ~in_valid_reg | out_advance;
    assign in_take     = in_ch.valid & in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= '0;
            invert_reg    <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_TOLERANCE: tolerance_reg <= cfg_data[TOL_W-1:0];
                REG_INVERT:    invert_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Input register: capture a transaction, drop the valid flag once passed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= in_ch.adc_sample;
            target_reg <= in_ch.target_position;
            mode_reg   <= in_ch.mode;
        end
    end

    adpc_scale u_scale (
        .adc_sample     (sample_reg),
        .invert_mapping (invert_reg),
        .position       (position)
    );

    adpc_decide u_decide (
        .position        (position),
        .target_position (target_reg),
        .mode            (mode_reg),
        .tolerance       (tolerance_reg),
        .invert_mapping  (invert_reg),
        .drive           (drive)
    );

    // Advance the remembered direction only with an item that moves on
    assign last_dir_next = in_advance ? drive.dir : last_dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_dir_reg  <= DIR_OFF;
        end
        else
        begin
            last_dir_reg <= last_dir_next;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Result register: load when the input stage hands over, else hold
    always_ff @(posedge clk)
    begin
        if (in_advance)
        begin
            position_reg  <= position;
            drive_pos_reg <= drive.drive_positive;
            drive_neg_reg <= drive.drive_negative;
            running_reg   <= (drive.dir != DIR_OFF);
            changed_reg   <= (drive.dir != last_dir_reg);
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.position          = position_reg;
    assign out_ch.drive_positive    = drive_pos_reg;
    assign out_ch.drive_negative    = drive_neg_reg;
    assign out_ch.running           = running_reg;
    assign out_ch.direction_changed = changed_reg;

endmodule
`default_nettype wire

FILE: sv/adpc_scale.sv
`default_nettype none
// ============================================================================
// adpc_scale
// Map a raw 10-bit sample onto the 10..520 position range.
// ============================================================================
module adpc_scale (
    input  wire logic [adpc_pkg::SAMPLE_W-1:0] adc_sample,
    input  wire logic                          invert_mapping,
    output logic      [adpc_pkg::POS_W-1:0]    position
);
    import adpc_pkg::*;

    logic [SAMPLE_W-1:0] x;
    logic [PROD_W-1:0]   prod;
    logic [8:0]          q_est;
    logic [10:0]         rem;
    logic [8:0]          quot;

    // 1023 - x equals the bitwise complement for a 10-bit value
    assign x    = invert_mapping ? ~adc_sample : adc_sample;
    assign prod = PROD_W'(x) * PROD_W'(SCALE_SPAN);

    // Divide by 1023: estimate with >>10, remainder is low bits plus estimate,
    // stays below 2*1023 so one correction step suffices
    assign q_est = prod[PROD_W-1:10];
    assign rem   = 11'(prod[9:0]) + 11'(q_est);
    assign quot  = (rem >= 11'(SAMPLE_MAX)) ? q_est + 9'd1 : q_est;

    assign position = POS_W'(quot) + POS_W'(POS_MIN);

endmodule
`default_nettype wire

FILE: sv/adpc_decide.sv
`default_nettype none
// ============================================================================
// adpc_decide
// Choose the drive direction and the drive line levels for one position.
// ============================================================================
module adpc_decide (
    input  wire logic [adpc_pkg::POS_W-1:0]    position,
    input  wire logic [adpc_pkg::TARGET_W-1:0] target_position,
    input  wire logic [adpc_pkg::MODE_W-1:0]   mode,
    input  wire logic [adpc_pkg::TOL_W-1:0]    tolerance,
    input  wire logic                          invert_mapping,
    output adpc_pkg::drive_t                   drive
);
    import adpc_pkg::*;

    logic signed [CMP_W-1:0] pos_s;
    logic signed [CMP_W-1:0] tgt_s;
    logic signed [CMP_W-1:0] lo_s;
    logic signed [CMP_W-1:0] hi_s;
    dir_t                    dir;

    assign pos_s = signed'(CMP_W'(position));
    assign tgt_s = signed'(CMP_W'(target_position));
    assign lo_s  = tgt_s - signed'(CMP_W'(tolerance));
    assign hi_s  = tgt_s + signed'(CMP_W'(tolerance));

    always_comb
    begin
        dir = DIR_OFF;
        case (mode)
            MODE_WINDOW:
            begin
                if (pos_s < lo_s)
                    dir = DIR_POS;
                else if (pos_s > hi_s)
                    dir = DIR_NEG;
            end
            MODE_AT_LEAST:
            begin
                if (pos_s < tgt_s)
                    dir = DIR_POS;
            end
            MODE_AT_MOST:
            begin
                if (pos_s > tgt_s)
                    dir = DIR_NEG;
            end
            default:
            begin
                dir = DIR_OFF;
            end
        endcase
    end

    // Swap the drive lines when the mapping is inverted
    always_comb
    begin
        drive.dir            = dir;
        drive.drive_positive = 1'b0;
        drive.drive_negative = 1'b0;
        case (dir)
            DIR_POS:
            begin
                drive.drive_positive = ~invert_mapping;
                drive.drive_negative = invert_mapping;
            end
            DIR_NEG:
            begin
                drive.drive_positive = invert_mapping;
                drive.drive_negative = ~invert_mapping;
            end
            default:
            begin
                drive.drive_positive = 1'b0;
                drive.drive_negative = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the deadband position control block: directed
// edge cases and constrained random feedback items under several tolerance
// and inversion settings, with random idling on both channels and a long
// receiver hold-off, checked transaction by transaction against a predictor.
// ============================================================================
module tb_top;
    import adpc_pkg::*;

    // Mode code the block has no name for; it must leave the motor off
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int PIPE_SETTLE    = 6;        // two stage pipe plus margin
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int PHASE_ITEMS    = 210;
    localparam int PHASE_COUNT    = 8;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             drive_positive;
        logic             drive_negative;
        logic             running;
        logic             direction_changed;
    } control_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the block's configuration and last direction, turns
    // each accepted feedback transaction into the expected control result and
    // checks results in order.
    // ------------------------------------------------------------------------
    class control_scoreboard;
        logic [TOL_W-1:0] tolerance;
        logic             invert;
        dir_t             last_dir;
        control_result_t  expected_q[$];
        int               failures;
        int               accepted;
        int               dir_changes;
        int               mode_count[4];
        int               dir_count[3];

        function new();
            tolerance   = '0;
            invert      = 1'b0;
            last_dir    = DIR_OFF;
            failures    = 0;
            accepted    = 0;
            dir_changes = 0;
            foreach (mode_count[i]) mode_count[i] = 0;
            foreach (dir_count[i]) dir_count[i] = 0;
        endfunction

        function int scaled_position(logic [SAMPLE_W-1:0] sample);
            int x;
            x = invert ? SAMPLE_MAX - int'(sample) : int'(sample);
            return x * SCALE_SPAN / SAMPLE_MAX + POS_MIN;
        endfunction

        function void report_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        function void note_input(logic [SAMPLE_W-1:0] sample,
                                 logic [TARGET_W-1:0] target,
                                 logic [MODE_W-1:0] mode);
            int              pos;
            int              tgt;
            int              tol;
            dir_t            dir;
            control_result_t r;
            pos = scaled_position(sample);
            tgt = int'(target);
            tol = int'(tolerance);
            dir = DIR_OFF;
            // Signed compares in int: the window bounds never wrap
            case (mode)
                MODE_WINDOW:
                begin
                    if (pos < tgt - tol)
                        dir = DIR_POS;
                    else if (pos > tgt + tol)
                        dir = DIR_NEG;
                end
                MODE_AT_LEAST:
                begin
                    if (pos < tgt)
                        dir = DIR_POS;
                end
                MODE_AT_MOST:
                begin
                    if (pos > tgt)
                        dir = DIR_NEG;
                end
                default: dir = DIR_OFF;
            endcase
            r.position          = POS_W'(pos);
            r.drive_positive    = (dir == DIR_POS) ? !invert : (dir == DIR_NEG) ? invert : 1'b0;
            r.drive_negative    = (dir == DIR_NEG) ? !invert : (dir == DIR_POS) ? invert : 1'b0;
            r.running           = (dir != DIR_OFF);
            r.direction_changed = (dir != last_dir);
            if (dir != last_dir)
                dir_changes++;
            last_dir = dir;
            accepted++;
            mode_count[mode]++;
            dir_count[dir]++;
            expected_q.push_back(r);
        endfunction

        function void check_result(control_result_t got);
            control_result_t want;
            if (expected_q.size() == 0)
            begin
                report_failure($sformatf("result with nothing expected: pos=%0d", got.position));
                return;
            end
            want = expected_q.pop_front();
            if (got.position !== want.position)
                report_failure($sformatf("position exp %0d got %0d",
                                         want.position, got.position));
            if (got.drive_positive !== want.drive_positive)
                report_failure($sformatf("drive_positive exp %b got %b (pos %0d)",
                                         want.drive_positive, got.drive_positive,
                                         want.position));
            if (got.drive_negative !== want.drive_negative)
                report_failure($sformatf("drive_negative exp %b got %b (pos %0d)",
                                         want.drive_negative, got.drive_negative,
                                         want.position));
            if (got.running !== want.running)
                report_failure($sformatf("running exp %b got %b (pos %0d)",
                                         want.running, got.running, want.position));
            if (got.direction_changed !== want.direction_changed)
                report_failure($sformatf("direction_changed exp %b got %b (pos %0d)",
                                         want.direction_changed, got.direction_changed,
                                         want.position));
        endfunction

        function void flush_leftover();
            while (expected_q.size() != 0)
            begin
                control_result_t lost;
                lost = expected_q.pop_front();
                report_failure($sformatf("expected result never arrived: pos=%0d",
                                         lost.position));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    adpc_in_if  in_ch ();
    adpc_out_if out_ch ();

    control_scoreboard sb = new();

    // Idling knobs shared by the driver, the receiver and the main sequence
    bit source_idle_enable = 1'b1;
    bit sink_idle_enable   = 1'b1;
    int hold_request       = 0;
    int settings_applied   = 0;

    always
    begin
        clk = 1'b0;
        #CLK_HALF_NS;
        clk = 1'b1;
        #CLK_HALF_NS;
    end

    actuator_deadband_position_control i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Idle gap length: mostly none or short, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: drive ready at the falling edge. A hold-off request from the
    // main sequence takes priority and is counted down here, cycle by cycle,
    // while the driver keeps offering transactions.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int gap_left;
        hold_left    = 0;
        gap_left     = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                out_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                gap_left = sink_idle_enable ? idle_length() : 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: sample at the rising edge, before the block updates
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        control_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.position          = out_ch.position;
            got.drive_positive    = out_ch.drive_positive;
            got.drive_negative    = out_ch.drive_negative;
            got.running           = out_ch.running;
            got.direction_changed = out_ch.direction_changed;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one feedback item; note it in the scoreboard once accepted.
    // Valid is only dropped during an idle gap, so back-to-back items keep it
    // high across the edge.
    task automatic send_item(input logic [SAMPLE_W-1:0] sample,
                             input logic [TARGET_W-1:0] target,
                             input logic [MODE_W-1:0]   mode);
        int gap;
        gap = source_idle_enable ? idle_length() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid           <= 1'b1;
        in_ch.adc_sample      <= sample;
        in_ch.target_position <= target;
        in_ch.mode            <= mode;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(sample, target, mode);
    endtask

    // Drop valid and wait until every expected result is in, then let the
    // pipe settle so the block is idle
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // Write both registers on consecutive cycles; the block is idle here
    task automatic apply_settings(input logic [TOL_W-1:0] tol, input logic inv);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_TOLERANCE;
        cfg_data     <= CFG_DATA_W'(tol);
        @(negedge clk);
        cfg_index    <= REG_INVERT;
        cfg_data     <= CFG_DATA_W'(inv);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        sb.tolerance = tol;
        sb.invert    = inv;
        settings_applied++;
    endtask

    // Random feedback items. Modes favor the three real ones; targets are
    // steered onto the deadband and compare edges a good share of the time.
    task automatic run_random(input int count);
        logic [SAMPLE_W-1:0] sample;
        logic [MODE_W-1:0]   mode;
        int                  tgt;
        int                  pos;
        int                  mr;
        int                  tr;
        for (int i = 0; i < count; i++)
        begin
            sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            mr     = $urandom_range(0, 19);
            if (mr < 8)
                mode = MODE_WINDOW;
            else if (mr < 13)
                mode = MODE_AT_LEAST;
            else if (mr < 18)
                mode = MODE_AT_MOST;
            else
                mode = MODE_UNUSED;
            pos = sb.scaled_position(sample);
            tr  = $urandom_range(0, 9);
            if (tr < 4)
            begin
                // Land on a bound or one step either side of it
                tgt = pos;
                if (mode == MODE_WINDOW)
                    tgt = $urandom_range(0, 1) ? pos + int'(sb.tolerance)
                                               : pos - int'(sb.tolerance);
                tgt = tgt + $urandom_range(0, 2) - 1;
                if (tgt < 0)
                    tgt = 0;
                if (tgt > 1023)
                    tgt = 1023;
            end
            else if (tr < 8)
                tgt = $urandom_range(0, 530);
            else
                tgt = $urandom_range(0, 1023);
            send_item(sample, TARGET_W'(tgt), mode);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TOL_W-1:0] tol;
        logic             inv;

        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.adc_sample      = '0;
        in_ch.target_position = '0;
        in_ch.mode            = MODE_WINDOW;
        cfg_write_en          = 1'b0;
        cfg_index             = REG_TOLERANCE;
        cfg_data              = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: wide deadband, plain mapping. Hit both window edges,
        // a lower bound below zero, the at-least / at-most edges, the full
        // scale ends and the unused mode.
        apply_settings(9'd300, 1'b0);
        send_item(10'd0,    10'd0,    MODE_WINDOW);
        send_item(10'd1023, 10'd1023, MODE_WINDOW);
        send_item(10'd0,    10'd310,  MODE_WINDOW);   // on the lower edge
        send_item(10'd0,    10'd311,  MODE_WINDOW);   // just outside it
        send_item(10'd1023, 10'd220,  MODE_WINDOW);   // on the upper edge
        send_item(10'd1023, 10'd219,  MODE_WINDOW);   // just outside it
        send_item(10'd512,  10'd5,    MODE_WINDOW);   // lower bound negative
        send_item(10'd0,    10'd10,   MODE_AT_LEAST);
        send_item(10'd0,    10'd11,   MODE_AT_LEAST);
        send_item(10'd1023, 10'd520,  MODE_AT_MOST);
        send_item(10'd1023, 10'd519,  MODE_AT_MOST);
        send_item(10'd1023, 10'd0,    MODE_AT_LEAST);
        send_item(10'd0,    10'd1023, MODE_AT_MOST);
        send_item(10'd341,  10'd682,  MODE_UNUSED);
        send_item(10'd682,  10'd341,  MODE_UNUSED);
        drain();

        // Directed: no deadband, inverted mapping and swapped drive lines
        apply_settings(9'd0, 1'b1);
        send_item(10'd0,    10'd520,  MODE_WINDOW);
        send_item(10'd1023, 10'd520,  MODE_WINDOW);
        send_item(10'd1023, 10'd0,    MODE_AT_MOST);
        send_item(10'd0,    10'd1023, MODE_AT_LEAST);
        send_item(10'd555,  10'd100,  MODE_UNUSED);
        send_item(10'd1023, 10'd11,   MODE_WINDOW);
        drain();

        // Random phases over a spread of settings, extremes first
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            source_idle_enable = 1'b1;
            sink_idle_enable   = 1'b1;
            case (ph)
                0: begin tol = 9'd0;   inv = 1'b0; end
                1: begin tol = 9'd510; inv = 1'b0; end
                2: begin tol = 9'd0;   inv = 1'b1; end
                3: begin tol = 9'd510; inv = 1'b1; end
                4: begin tol = TOL_W'($urandom_range(1, 40));  inv = 1'b0; end
                5: begin tol = TOL_W'($urandom_range(0, 510)); inv = 1'b1; end
                6: begin tol = TOL_W'($urandom_range(0, 15));  inv = 1'($urandom); end
                default: begin tol = TOL_W'($urandom_range(0, 510)); inv = 1'($urandom); end
            endcase
            apply_settings(tol, inv);
            // Hold the receiver off for a long stretch so both stages fill
            // and the input stalls while items keep coming
            if (ph == 3)
                hold_request = HOLD_OFF_LEN;
            // Run one phase flat out on both sides
            if (ph == 4)
            begin
                source_idle_enable = 1'b0;
                sink_idle_enable   = 1'b0;
            end
            run_random(PHASE_ITEMS);
            drain();
        end

        sb.flush_leftover();
        $display("Covered %0d transactions over %0d register settings, %0d direction changes.",
                 sb.accepted, settings_applied, sb.dir_changes);
        $display("Modes window/at-least/at-most/unused: %0d/%0d/%0d/%0d; off/pos/neg: %0d/%0d/%0d",
                 sb.mode_count[0], sb.mode_count[1], sb.mode_count[2], sb.mode_count[3],
                 sb.dir_count[0], sb.dir_count[1], sb.dir_count[2]);
        if (sb.failures > REPORT_LIMIT)
            $display("%0d mismatches in total", sb.failures);
        if (sb.failures == 0)
            $display("actuator_deadband_position_control test passed");
        else
            $display("actuator_deadband_position_control test failed");
        $finish;
    end

    // Watchdog: end the run if it hangs
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
        $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("actuator_deadband_position_control test failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/adpc_pkg.sv
sv/adpc_if.sv
sv/adpc_scale.sv
sv/adpc_decide.sv
sv/actuator_deadband_position_control.sv
tb/tb_top.sv
